>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define FCIM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcim assertion failed");

// Next-cycle implication
`define FCIM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcim assertion failed");

`endif

>>> hw/rtl/fcim_pkg.sv
// ----------------------------------------------------------------------------
// fcim_pkg
// Types, codes and widths shared by the filter clog monitor modules.
// ----------------------------------------------------------------------------
package fcim_pkg;

  localparam int unsigned MAX_POINTS_DEF = 8;

  // Field widths
  localparam int unsigned SPD_W    = 7;
  localparam int unsigned DROP_W   = 24;
  localparam int unsigned FAN_W    = 15;
  localparam int unsigned DIFF_W   = 25;
  localparam int unsigned HELD_W   = 4;
  localparam int unsigned MARGIN_W = 7;
  localparam int unsigned PCT_W    = 8;

  // Shared multiplier and result widths
  localparam int unsigned MUL_A_W = 43;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned LHS_W   = 48;

  localparam logic [PCT_W-1:0]    PCT_FULL   = 8'd100;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 7'd30;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_OK   = 2'd1,
    VERDICT_CLOG = 2'd2
  } verdict_e;

  typedef enum logic {
    REG_ENABLE = 1'b0,
    REG_MARGIN = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_CMP
  } state_e;

  // Table update request from the sequencer
  typedef struct packed {
    logic              clear;
    logic              insert;
    logic [SPD_W-1:0]  spd;
    logic [DROP_W-1:0] drop;
  } tbl_ctrl_t;

endpackage

>>> hw/rtl/fcim_table.sv
// ----------------------------------------------------------------------------
// fcim_table
// Sorted calibration table: ordered insert, clear, one read port.
// ----------------------------------------------------------------------------
module fcim_table import fcim_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbl_ctrl_t         ctrl_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  output logic [SPD_W-1:0]  rd_spd_o,
  output logic [DROP_W-1:0] rd_drop_o,
  output logic [CNT_W-1:0]  total_o
);

  logic [SPD_W-1:0]  spd_q  [MAX_POINTS];
  logic [DROP_W-1:0] drop_q [MAX_POINTS];
  logic [CNT_W-1:0]  total_q;
  logic              do_ins;

  // Drop the insert when the table is full
  assign do_ins = ctrl_i.insert && (total_q < CNT_W'(MAX_POINTS));

  // Each entry either takes the new point, shifts up from below, or holds
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ent
    logic at_top;
    logic above_new;
    logic wr_en;

    assign at_top    = (CNT_W'(k) == total_q);
    assign above_new = (CNT_W'(k) < total_q) && (spd_q[k] > ctrl_i.spd);
    assign wr_en     = do_ins && (at_top || above_new);

    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (wr_en) begin
          spd_q[k]  <= ctrl_i.spd;
          drop_q[k] <= ctrl_i.drop;
        end
      end
    end else begin : g_rest
      logic below_ok;
      assign below_ok = (spd_q[k-1] <= ctrl_i.spd);

      always_ff @(posedge clk_i) begin
        if (wr_en) begin
          if (below_ok) begin
            spd_q[k]  <= ctrl_i.spd;
            drop_q[k] <= ctrl_i.drop;
          end else begin
            spd_q[k]  <= spd_q[k-1];
            drop_q[k] <= drop_q[k-1];
          end
        end
      end
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (ctrl_i.clear) begin
      total_q <= '0;
    end else if (do_ins) begin
      total_q <= total_q + CNT_W'(1);
    end
  end

  assign rd_spd_o  = spd_q[rd_idx_i];
  assign rd_drop_o = drop_q[rd_idx_i];
  assign total_o   = total_q;

endmodule

>>> hw/rtl/fcim_mul.sv
// ----------------------------------------------------------------------------
// fcim_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fcim_mul import fcim_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Capture the product only in multiply steps
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> hw/rtl/filter_clog_interp_monitor.sv
// ----------------------------------------------------------------------------
// filter_clog_interp_monitor
// Filter clog monitor with a sorted calibration table and exact interpolation.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Clear, add and unused commands finish at the
// beat where they are accepted and their result shows in the next cycle. A
// check with monitoring on, a non-empty table and a valid reading walks the
// table one entry per cycle until it finds the segment around the fan speed,
// then runs five steps on the single shared multiplier and one compare step.
// A check that fails any of those three conditions finishes like an unused
// command. The next beat is taken once the sequencer is idle and the output
// register is free or being emptied.
module filter_clog_interp_monitor import fcim_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] point_speed, [30:7] point_drop, [45:31] fan_speed,
  // [69:46] measured_drop, [70] reading_valid, [71] zero
  input  logic [71:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] verdict, [5:2] points_held, [6] add_rejected, [7] zero
  output logic [7:0]  m_axis_tdata,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                enable_q;
  logic [MARGIN_W-1:0] margin_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      margin_q <= MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE: enable_q <= pwdata[0];
        REG_MARGIN: margin_q <= pwdata[MARGIN_W-1:0];
        default:    enable_q <= enable_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE: prdata = {31'd0, enable_q};
      REG_MARGIN: prdata = {{(32-MARGIN_W){1'b0}}, margin_q};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input unpacking
  // --------------------------------------------------------------------------
  cmd_e              in_cmd;
  logic [SPD_W-1:0]  in_spd;
  logic [DROP_W-1:0] in_pdrop;
  logic [FAN_W-1:0]  in_fan;
  logic [DROP_W-1:0] in_meas;
  logic              in_rv;

  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_spd   = s_axis_tdata[6:0];
  assign in_pdrop = s_axis_tdata[30:7];
  assign in_fan   = s_axis_tdata[45:31];
  assign in_meas  = s_axis_tdata[69:46];
  assign in_rv    = s_axis_tdata[70];

  // --------------------------------------------------------------------------
  // Calibration table
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  tbl_ctrl_t         tbl_ctrl;
  logic [IDX_W-1:0]  idx_q;
  logic [SPD_W-1:0]  rd_spd;
  logic [DROP_W-1:0] rd_drop;
  logic [CNT_W-1:0]  total;
  logic              in_acc;
  logic              out_free;
  logic              out_valid_q;
  logic              full;
  logic              go_check;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (total == CNT_W'(MAX_POINTS));
  assign go_check      = (in_cmd == CMD_CHECK) && enable_q && (total != '0) && in_rv;

  assign tbl_ctrl.clear  = in_acc && (in_cmd == CMD_CLEAR);
  assign tbl_ctrl.insert = in_acc && (in_cmd == CMD_ADD);
  assign tbl_ctrl.spd    = in_spd;
  assign tbl_ctrl.drop   = in_pdrop;

  fcim_table #(
    .MAX_POINTS (MAX_POINTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tbl_ctrl),
    .rd_idx_i  (idx_q),
    .rd_spd_o  (rd_spd),
    .rd_drop_o (rd_drop),
    .total_o   (total)
  );

  // --------------------------------------------------------------------------
  // Table walk: find the segment around the fan speed
  // --------------------------------------------------------------------------
  logic [FAN_W-1:0]         sp_q;
  logic signed [DROP_W-1:0] meas_q;
  logic [SPD_W-1:0]         prev_s_q;
  logic signed [DROP_W-1:0] prev_d_q;
  logic signed [DROP_W-1:0] d0_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic [FAN_W-1:0]         num_q;
  logic [FAN_W-1:0]         den_q;
  logic [FAN_W-1:0]         rd_s256;
  logic                     idx_first;
  logic                     idx_last;
  logic                     hit;

  assign rd_s256   = {rd_spd, 8'd0};
  assign idx_first = (idx_q == '0);
  assign idx_last  = (CNT_W'(idx_q) == (total - CNT_W'(1)));
  assign hit       = idx_first ? (sp_q <= rd_s256) : (sp_q < rd_s256);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (in_acc) begin
      idx_q <= '0;
    end else if (state_q == ST_WALK) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sp_q   <= in_fan;
      meas_q <= $signed(in_meas);
    end
    if (state_q == ST_WALK) begin
      prev_s_q <= rd_spd;
      prev_d_q <= $signed(rd_drop);
      if (hit && !idx_first) begin
        // Interpolate between the previous entry and this one
        d0_q   <= prev_d_q;
        diff_q <= DIFF_W'($signed(rd_drop)) - DIFF_W'(prev_d_q);
        num_q  <= sp_q - {prev_s_q, 8'd0};
        den_q  <= {rd_spd - prev_s_q, 8'd0};
      end else if (hit || idx_last) begin
        // Clamp to this end point
        d0_q   <= $signed(rd_drop);
        diff_q <= '0;
        num_q  <= '0;
        den_q  <= FAN_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && go_check) state_d = ST_WALK;
      ST_WALK: if (hit || idx_last) state_d = ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_CMP;
      ST_CMP:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier operands
  //   MUL0 d0*den, MUL1 num*diff, MUL2 meas*den, MUL3 (meas*den)*100,
  //   MUL4 e_num*(100+margin)
  // --------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_A_W-1:0] acc_q;
  logic signed [LHS_W-1:0]   lhs_q;
  logic [PCT_W-1:0]          pct_lim;

  assign pct_lim = PCT_FULL + PCT_W'(margin_q);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (state_q)
      ST_MUL0: begin
        mul_a  = MUL_A_W'(d0_q);
        mul_b  = $signed(MUL_B_W'(den_q));
        mul_en = 1'b1;
      end
      ST_MUL1: begin
        mul_a  = MUL_A_W'(diff_q);
        mul_b  = $signed(MUL_B_W'(num_q));
        mul_en = 1'b1;
      end
      ST_MUL2: begin
        mul_a  = MUL_A_W'(meas_q);
        mul_b  = $signed(MUL_B_W'(den_q));
        mul_en = 1'b1;
      end
      ST_MUL3: begin
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = $signed(MUL_B_W'(PCT_FULL));
        mul_en = 1'b1;
      end
      ST_MUL4: begin
        mul_a  = acc_q;
        mul_b  = $signed(MUL_B_W'(pct_lim));
        mul_en = 1'b1;
      end
      default: mul_en = 1'b0;
    endcase
  end

  fcim_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Accumulate the expected-drop numerator and hold the left side
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL1: acc_q <= prod[MUL_A_W-1:0];
      ST_MUL2: acc_q <= acc_q + prod[MUL_A_W-1:0];
      ST_MUL4: lhs_q <= prod[LHS_W-1:0];
      default: acc_q <= acc_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  verdict_e          verdict_q;
  verdict_e          cmp_verdict;
  logic [HELD_W-1:0] held_q;
  logic              rej_q;
  logic              load_direct;
  logic              load_cmp;
  logic [CNT_W-1:0]  held_direct;

  assign load_direct = in_acc && !go_check;
  assign load_cmp    = (state_q == ST_CMP) && out_free;

  // A zero or negative expected drop gives no verdict
  always_comb begin
    if (acc_q[MUL_A_W-1] || (acc_q == '0)) begin
      cmp_verdict = VERDICT_NONE;
    end else if (PROD_W'(lhs_q) > prod) begin
      cmp_verdict = VERDICT_CLOG;
    end else begin
      cmp_verdict = VERDICT_OK;
    end
  end

  always_comb begin
    case (in_cmd)
      CMD_CLEAR: held_direct = '0;
      CMD_ADD:   held_direct = full ? total : total + CNT_W'(1);
      default:   held_direct = total;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_direct || load_cmp) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      verdict_q <= VERDICT_NONE;
      held_q    <= HELD_W'(held_direct);
      rej_q     <= (in_cmd == CMD_ADD) && full;
    end else if (load_cmp) begin
      verdict_q <= cmp_verdict;
      held_q    <= HELD_W'(total);
      rej_q     <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, rej_q, held_q, verdict_q};

endmodule

>>> hw/rtl/fcim_checker.sv
// ----------------------------------------------------------------------------
// fcim_checker
// Port-level assertions for the filter clog monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcim_checker import fcim_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A new beat is taken only when the result slot is free or draining
  `FCIM_ASSERT_NOW(a_in_needs_slot, in_beat, !m_axis_tvalid || m_axis_tready)

  // Commands other than check answer in the next cycle
  `FCIM_ASSERT_NEXT(a_quick_result, in_beat && (s_axis_tuser != CMD_CHECK), m_axis_tvalid)

  // A rejected add reports a full table
  `FCIM_ASSERT_NOW(a_reject_full, m_axis_tvalid && m_axis_tdata[6], (MAX_POINTS > 15) || (m_axis_tdata[5:2] == 4'(MAX_POINTS)))

  // A stalled result holds
  `FCIM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind filter_clog_interp_monitor fcim_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_fcim_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: filter clog monitor testbench
// Streams clear, add, check and unused commands into the monitor under several
// enable and margin settings. A scoreboard keeps its own copy of the sorted
// calibration table, predicts verdict, point count and add rejection for every
// accepted beat, and compares each result beat in order. Both streams idle at
// random, and one phase stalls the result side long enough to back up input.
// ----------------------------------------------------------------------------
module tb;
  import fcim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS      = MAX_POINTS_DEF;
  localparam int          LONG_HOLD = 400;
  localparam int          IDLE_LIM  = 3000;
  localparam int          TAIL_WAIT = 2 * (NPTS + 7);

  localparam logic [23:0] DROP_MIN = 24'h800000;
  localparam logic [23:0] DROP_MAX = 24'h7FFFFF;

  typedef struct {
    cmd_e               cmd;
    logic [6:0]         spd;
    logic signed [23:0] pdrop;
    logic [14:0]        fan;
    logic signed [23:0] meas;
    logic               vld;
  } cmd_beat_t;

  typedef struct {
    verdict_e   verdict;
    logic [3:0] held;
    logic       rejected;
  } status_t;

  // Scoreboard: private table copy, verdict prediction and in-order compare
  class clog_scoreboard;
    logic [6:0]         tbl_spd[NPTS];
    logic signed [23:0] tbl_drop[NPTS];
    int unsigned        n_pts;
    bit                 enable;
    int unsigned        margin;
    status_t            status_q[$];
    int                 errors;

    function new();
      n_pts  = 0;
      enable = 1'b0;
      margin = MARGIN_RST;
      errors = 0;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] value);
      if (idx == REG_ENABLE) enable = value[0];
      else margin = value[6:0];
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Expected drop by cross-multiplied interpolation, then margin compare
    function verdict_e judge(cmd_beat_t b);
      longint sp, d0, d1, num, den, e_num, lhs, rhs, s0, s1;
      if (!enable || n_pts == 0 || !b.vld) return VERDICT_NONE;
      sp  = longint'(b.fan);
      d0  = longint'(tbl_drop[0]);
      d1  = d0;
      num = 0;
      den = 1;
      if (n_pts > 1 && sp > longint'(tbl_spd[0]) * 256) begin
        if (sp >= longint'(tbl_spd[n_pts-1]) * 256) begin
          d0 = longint'(tbl_drop[n_pts-1]);
          d1 = d0;
        end else begin
          d0 = 0;
          d1 = 0;
          for (int i = 0; i + 1 < n_pts; i++) begin
            s0 = longint'(tbl_spd[i]) * 256;
            s1 = longint'(tbl_spd[i+1]) * 256;
            if (sp >= s0 && sp < s1) begin
              d0  = longint'(tbl_drop[i]);
              d1  = longint'(tbl_drop[i+1]);
              num = sp - s0;
              den = s1 - s0;
              break;
            end
          end
        end
      end
      e_num = d0 * den + num * (d1 - d0);
      if (e_num <= 0) return VERDICT_NONE;
      lhs = longint'(b.meas) * 100 * den;
      rhs = longint'(100 + margin) * e_num;
      return (lhs > rhs) ? VERDICT_CLOG : VERDICT_OK;
    endfunction

    // Apply an accepted command to the table copy and queue its status
    function void note_input(cmd_beat_t b);
      status_t     st;
      int unsigned pos;
      st.verdict  = VERDICT_NONE;
      st.rejected = 1'b0;
      case (b.cmd)
        CMD_CLEAR: n_pts = 0;
        CMD_ADD: begin
          if (n_pts >= NPTS) begin
            st.rejected = 1'b1;
          end else begin
            // shift larger speeds up; equal speeds stay ahead of the new point
            pos = n_pts;
            while (pos > 0 && tbl_spd[pos-1] > b.spd) begin
              tbl_spd[pos]  = tbl_spd[pos-1];
              tbl_drop[pos] = tbl_drop[pos-1];
              pos--;
            end
            tbl_spd[pos]  = b.spd;
            tbl_drop[pos] = b.pdrop;
            n_pts++;
          end
        end
        CMD_CHECK: st.verdict = judge(b);
        default: ;
      endcase
      st.held = n_pts[3:0];
      status_q.push_back(st);
    endfunction

    function void check_result(logic [7:0] beat);
      status_t want;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", beat);
        return;
      end
      want = status_q.pop_front();
      if (beat[1:0] !== want.verdict || beat[5:2] !== want.held ||
          beat[6] !== want.rejected) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: verdict exp %0d got %0d, held exp %0d got %0d, rejected exp %0d got %0d",
                   want.verdict, beat[1:0], want.held, beat[5:2], want.rejected, beat[6]);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [6:0] point_speed, [30:7] point_drop, [45:31] fan_speed,
  // [69:46] measured_drop, [70] reading_valid, [71] zero
  logic [71:0] s_axis_tdata = '0;
  // [1:0] command
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] verdict, [5:2] points_held, [6] add_rejected, [7] zero
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clog_scoreboard sb = new();

  bit tx_gaps;
  bit rx_stalls;
  int hold_asked;
  int sent;

  filter_clog_interp_monitor dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Hand one beat to the block and return at the edge where it is taken
  task automatic send_item(input cmd_e cmd, input logic [6:0] spd, input logic [23:0] pdrop,
                           input logic [14:0] fan, input logic [23:0] meas, input logic vld);
    int gap;
    gap = tx_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, vld, meas, fan, pdrop, spd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid and wait until every predicted status has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at its end
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Mostly clear/fill/check sequences with random content, some raw noise
  task automatic run_random(input int n_items);
    int         k;
    logic [6:0] spd;
    logic [23:0] pdrop;
    logic [14:0] fan;
    logic [23:0] meas;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 2) != 0)
          send_item(CMD_CLEAR, 7'($urandom), 24'($urandom), 15'($urandom), 24'($urandom), 1'($urandom));
        k = $urandom_range(1, NPTS + 1);
        repeat (k) begin
          case ($urandom_range(0, 9))
            0:       spd = 7'($urandom);
            1, 2:    spd = 7'(10 * $urandom_range(2, 6));
            default: spd = 7'($urandom_range(0, 100));
          endcase
          case ($urandom_range(0, 9))
            0:       pdrop = 24'($urandom);
            1:       pdrop = -24'($urandom_range(0, 3000));
            default: pdrop = 24'($urandom_range(500, 8000));
          endcase
          send_item(CMD_ADD, spd, pdrop, 15'($urandom), 24'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(2, 8)) begin
          fan  = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25600));
          meas = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 15000));
          send_item(CMD_CHECK, 7'($urandom), 24'($urandom), fan, meas,
                    $urandom_range(0, 9) != 0);
        end
      end else begin
        send_item(cmd_e'($urandom_range(0, 3)), 7'($urandom), 24'($urandom),
                  15'($urandom), 24'($urandom), 1'($urandom));
      end
    end
  endtask

  // Observe both streams at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input('{cmd_e'(s_axis_tuser), s_axis_tdata[6:0], s_axis_tdata[30:7],
                        s_axis_tdata[45:31], s_axis_tdata[69:46], s_axis_tdata[70]});
    end
  end

  // Result side: random stalls, plus a long hold when asked
  initial begin : result_sink
    int stall_left;
    int hold_done;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_asked) begin
        hold_done  = hold_asked;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End the run if no beat moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIM) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    tx_gaps    = 1'b1;
    rx_stalls  = 1'b1;
    hold_asked = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, clamping, interpolation, equal speeds, full table
    write_reg(REG_ENABLE, 32'd1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd0, 24'd5000, 1'b1);
    send_item(CMD_ADD, 7'd50, 24'd1000, 15'd0, 24'd0, 1'b0);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd0, 24'd1301, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd0, 24'd1300, 1'b1);
    send_item(CMD_ADD, 7'd20, 24'd500, 15'd0, 24'd0, 1'b0);
    send_item(CMD_ADD, 7'd80, 24'd2000, 15'd0, 24'd0, 1'b0);
    send_item(CMD_ADD, 7'd50, 24'd1500, 15'd0, 24'd0, 1'b0);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd0, 24'd700, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'h7FFF, 24'd2500, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'(35 * 256 + 128), 24'd1100, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'(50 * 256), 24'd1700, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'(40 * 256), 24'd9000, 1'b0);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'(60 * 256), DROP_MIN, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'(60 * 256), DROP_MAX, 1'b1);
    send_item(CMD_ADD, 7'd100, DROP_MIN, 15'd0, 24'd0, 1'b0);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd25600, 24'd100, 1'b1);
    send_item(CMD_ADD, 7'd127, DROP_MAX, 15'h7FFF, DROP_MAX, 1'b1);
    send_item(CMD_ADD, 7'd0, 24'd0, 15'd0, 24'd0, 1'b0);
    send_item(CMD_ADD, 7'd60, 24'd1, 15'd0, 24'd0, 1'b0);
    send_item(CMD_ADD, 7'd5, 24'd5, 15'd0, 24'd0, 1'b0);
    send_item(CMD_NONE, 7'h7F, DROP_MAX, 15'h7FFF, DROP_MIN, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd30000, DROP_MAX, 1'b1);
    send_item(CMD_CLEAR, 7'h7F, DROP_MIN, 15'h7FFF, DROP_MAX, 1'b1);
    send_item(CMD_CHECK, 7'd0, 24'd0, 15'd1000, 24'd3000, 1'b1);
    drain();

    // Low margin with idling on both sides
    write_reg(REG_MARGIN, 32'd10);
    run_random(100);
    drain();

    // Widest margin; hold the result side so the block backs up its input
    write_reg(REG_MARGIN, 32'd127);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_asked++;
    run_random(100);
    drain();

    // Monitoring off
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    write_reg(REG_ENABLE, 32'd0);
    write_reg(REG_MARGIN, 32'd90);
    run_random(100);
    drain();

    // Zero margin
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_MARGIN, 32'd0);
    run_random(100);
    drain();

    // Top of the nominal range, no idling at all
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    write_reg(REG_MARGIN, 32'd90);
    run_random(100);
    drain();

    // Random nominal margin, idling back on
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    write_reg(REG_MARGIN, 32'($urandom_range(10, 90)));
    run_random(100);
    drain();

    // Catch any stray result beats
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
